### rtl/core/radial_force_field_accumulate_assert.svh
// Assertion macros shared by the radial force field accumulator.
// No dependencies; included by the modules that carry assertions.
`ifndef RADIAL_FORCE_FIELD_ACCUMULATE_ASSERT_SVH
`define RADIAL_FORCE_FIELD_ACCUMULATE_ASSERT_SVH

// Same-cycle implication.
`define RFFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radial force field check failed");

// Next-cycle implication.
`define RFFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radial force field check failed");

`endif

### rtl/core/rffa_pkg.sv
// Package of the radial force field accumulator: codes, types and helpers.
// No dependencies; used by the top level, the field table and the divide / square root unit.
package rffa_pkg;

    localparam int MAX_FIELDS_DEF = 16;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_PARTICLE = 1'b1;

    localparam logic CFG_FIELDS = 1'b0;
    localparam logic CFG_MODE   = 1'b1;

    localparam logic [1:0] MODE_EXPLODE = 2'd0;
    localparam logic [1:0] MODE_IMPLODE = 2'd1;
    localparam logic [1:0] MODE_FALLOFF = 2'd2;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [30:0] radius;
        logic signed [31:0] strength;
    } rffa_entry_t;

    // Control of the shared divide / square root unit.
    typedef struct packed {
        logic start;
        logic sqrt_op;
    } rffa_unit_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/core/radial_force_field_accumulate.sv
// Top level of the radial force field accumulator: sequencer and datapath.
// Depends on rffa_pkg, rffa_table, rffa_mul, rffa_divsqrt and the assert header.
//
// Usage: the input channel (in_valid / in_stall) carries one item at a time.
// A load item (func = 0) writes one field table entry and
// gives no result. A particle item (func = 1) walks table entries 0 to
// min(fields_in_use, MAX_FIELDS) - 1 and gives one result item on the output channel
// (out_valid / out_stall) with the accumulated, saturated force.
// in_stall is high while a particle item is being worked on.
// Per particle item, each field in explode and implode modes uses one
// shared multiplier, used in turn per axis; in falloff mode one square root
// and up to four divisions run on the shared unit at one bit per cycle.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle; the block does not enforce this.
// Reset clears the sequencer, the result valid and both registers; the field
// table holds no defined value until it is loaded.
// A result waits in the output register while out_stall is high; the next
// particle can finish only once it has been taken.
`include "radial_force_field_accumulate_assert.svh"

module radial_force_field_accumulate #(
    parameter int MAX_FIELDS = rffa_pkg::MAX_FIELDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [3:0]         index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [30:0]        field_reach,
    input  logic signed [31:0] field_gain,
    input  logic signed [31:0] force_in_x,
    input  logic signed [31:0] force_in_y,
    input  logic signed [31:0] force_in_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] force_out_x,
    output logic signed [31:0] force_out_y,
    output logic signed [31:0] force_out_z,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);

    localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CW = $clog2(MAX_FIELDS + 1);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b00000000000000001,
        S_READ   = 17'b00000000000000010,
        S_DIFF   = 17'b00000000000000100,
        S_SQ     = 17'b00000000000001000,
        S_SQACC  = 17'b00000000000010000,
        S_RR     = 17'b00000000000100000,
        S_TEST   = 17'b00000000001000000,
        S_EXP    = 17'b00000000010000000,
        S_EXPACC = 17'b00000000100000000,
        S_SQRT   = 17'b00000001000000000,
        S_MM     = 17'b00000010000000000,
        S_MMST   = 17'b00000100000000000,
        S_MMWAIT = 17'b00001000000000000,
        S_Q      = 17'b00010000000000000,
        S_QST    = 17'b00100000000000000,
        S_QWAIT  = 17'b01000000000000000,
        S_FIN    = 17'b10000000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fld_reg, fld_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [1:0]          ax_reg, ax_next;
    logic [4:0]          fields_in_use_reg, fields_in_use_next;
    logic [1:0]          field_mode_reg, field_mode_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [31:0]  pos_reg [3];
    logic signed [31:0]  pos_next [3];
    logic signed [63:0]  acc_reg [3];
    logic signed [63:0]  acc_next [3];
    logic [32:0]         dmag_reg [3];
    logic [32:0]         dmag_next [3];
    logic [2:0]          dneg_reg, dneg_next;
    logic                inside_reg, inside_next;
    logic [63:0]         sum_reg, sum_next;
    logic [30:0]         r_reg, r_next;
    logic signed [31:0]  s_reg, s_next;
    logic [31:0]         d_reg, d_next;
    logic [31:0]         mm_reg, mm_next;
    logic signed [31:0]  fo_x_reg, fo_x_next;
    logic signed [31:0]  fo_y_reg, fo_y_next;
    logic signed [31:0]  fo_z_reg, fo_z_next;

    logic                     accept;
    logic                     tbl_we;
    logic [AW+3:0]            idx_ext;
    rffa_pkg::rffa_entry_t    tbl_wdata;
    rffa_pkg::rffa_entry_t    tbl_rdata;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [65:0]       mul_p;
    rffa_pkg::rffa_unit_ctl_t unit_ctl;
    logic [63:0]              unit_num;
    logic [31:0]              unit_den;
    logic                     unit_done;
    logic [31:0]              unit_res;
    logic signed [32:0]       diff_w [3];
    logic signed [31:0]       ctr_w [3];
    logic [31:0]              s_mag;
    logic signed [65:0]       prod_sel;
    logic signed [65:0]       contrib;
    logic                     fld_done;
    logic                     q_neg;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign idx_ext  = {{AW{1'b0}}, index};
    assign tbl_we   = accept && (func == rffa_pkg::FUNC_LOAD) && (32'(index) < MAX_FIELDS);
    assign tbl_wdata = '{cx: coord_x, cy: coord_y, cz: coord_z,
                         radius: field_reach, strength: field_gain};

    rffa_table #(
        .MAX_FIELDS(MAX_FIELDS),
        .AW        (AW)
    ) u_table (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(idx_ext[AW-1:0]),
        .wdata(tbl_wdata),
        .raddr(fld_reg[AW-1:0]),
        .rdata(tbl_rdata)
    );

    rffa_mul u_mul (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (mul_p)
    );

    rffa_divsqrt u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (unit_ctl),
        .num   (unit_num),
        .den   (unit_den),
        .done  (unit_done),
        .result(unit_res)
    );

    assign ctr_w[0] = tbl_rdata.cx;
    assign ctr_w[1] = tbl_rdata.cy;
    assign ctr_w[2] = tbl_rdata.cz;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            diff_w[a] = {pos_reg[a][31], pos_reg[a]} - {ctr_w[a][31], ctr_w[a]};
    end

    assign s_mag = s_reg[31] ? 32'(-s_reg) : 32'(s_reg);
    assign q_neg = (!dneg_reg[ax_reg]) != s_reg[31];

    always_comb
    begin
        state_next         = state_reg;
        fld_next           = fld_reg;
        n_next             = n_reg;
        ax_next            = ax_reg;
        fields_in_use_next = fields_in_use_reg;
        field_mode_next    = field_mode_reg;
        out_valid_next     = out_valid_reg;
        pos_next           = pos_reg;
        acc_next           = acc_reg;
        dmag_next          = dmag_reg;
        dneg_next          = dneg_reg;
        inside_next        = inside_reg;
        sum_next           = sum_reg;
        r_next             = r_reg;
        s_next             = s_reg;
        d_next             = d_reg;
        mm_next            = mm_reg;
        fo_x_next          = fo_x_reg;
        fo_y_next          = fo_y_reg;
        fo_z_next          = fo_z_reg;
        mul_a              = '0;
        mul_b              = '0;
        unit_ctl           = '0;
        unit_num           = sum_reg;
        unit_den           = d_reg;
        prod_sel           = mul_p;
        contrib            = mul_p >>> 16;
        fld_done           = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                rffa_pkg::CFG_FIELDS: fields_in_use_next = cfg_data;
                rffa_pkg::CFG_MODE:   field_mode_next    = cfg_data[1:0];
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (func == rffa_pkg::FUNC_PARTICLE))
                begin
                    pos_next[0] = coord_x;
                    pos_next[1] = coord_y;
                    pos_next[2] = coord_z;
                    acc_next[0] = {{32{force_in_x[31]}}, force_in_x};
                    acc_next[1] = {{32{force_in_y[31]}}, force_in_y};
                    acc_next[2] = {{32{force_in_z[31]}}, force_in_z};
                    fld_next    = '0;
                    if (32'(fields_in_use_reg) > MAX_FIELDS)
                        n_next = CW'(MAX_FIELDS);
                    else
                        n_next = CW'(fields_in_use_reg);
                    state_next = (fields_in_use_reg == 5'd0) ? S_FIN : S_READ;
                end
            end
            S_READ:
                state_next = S_DIFF;
            S_DIFF:
            begin
                inside_next = 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    dneg_next[a] = diff_w[a][32];
                    dmag_next[a] = diff_w[a][32] ? 33'(-diff_w[a]) : 33'(diff_w[a]);
                    if (dmag_next[a] >= {2'b00, tbl_rdata.radius})
                        inside_next = 1'b0;
                end
                r_next     = tbl_rdata.radius;
                s_next     = tbl_rdata.strength;
                sum_next   = '0;
                ax_next    = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                mul_a      = {1'b0, dmag_reg[ax_reg][31:0]};
                mul_b      = {1'b0, dmag_reg[ax_reg][31:0]};
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                if (dmag_reg[ax_reg] < {2'b00, r_reg})
                    sum_next = sum_reg + mul_p[63:0];
                if (ax_reg == 2'd2)
                    state_next = S_RR;
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_RR:
            begin
                mul_a      = {2'b00, r_reg};
                mul_b      = {2'b00, r_reg};
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // Outside the sphere, or exactly on the center: no contribution.
                if (!inside_reg || (sum_reg >= mul_p[63:0]) || (sum_reg == 64'd0))
                    fld_done = 1'b1;
                else
                begin
                    unique case (field_mode_reg)
                        rffa_pkg::MODE_EXPLODE, rffa_pkg::MODE_IMPLODE:
                        begin
                            ax_next    = '0;
                            state_next = S_EXP;
                        end
                        rffa_pkg::MODE_FALLOFF:
                        begin
                            unit_ctl.start   = 1'b1;
                            unit_ctl.sqrt_op = 1'b1;
                            unit_num         = sum_reg;
                            state_next       = S_SQRT;
                        end
                        default:
                            fld_done = 1'b1;
                    endcase
                end
            end
            S_EXP:
            begin
                mul_a      = dneg_reg[ax_reg] ? -{1'b0, dmag_reg[ax_reg][31:0]}
                                              : {1'b0, dmag_reg[ax_reg][31:0]};
                mul_b      = {s_reg[31], s_reg};
                state_next = S_EXPACC;
            end
            S_EXPACC:
            begin
                // Negate before the shift so that the floor is taken on the final sign.
                prod_sel = (field_mode_reg == rffa_pkg::MODE_IMPLODE) ? -mul_p : mul_p;
                contrib  = prod_sel >>> 16;
                acc_next[ax_reg] = acc_reg[ax_reg] + contrib[63:0];
                if (ax_reg == 2'd2)
                    fld_done = 1'b1;
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_EXP;
                end
            end
            S_SQRT:
            begin
                if (unit_done)
                begin
                    d_next     = unit_res;
                    state_next = S_MM;
                end
            end
            S_MM:
            begin
                mul_a      = {1'b0, s_mag};
                mul_b      = {1'b0, {1'b0, r_reg} - d_reg};
                state_next = S_MMST;
            end
            S_MMST:
            begin
                unit_ctl.start = 1'b1;
                unit_num       = mul_p[63:0];
                unit_den       = {1'b0, r_reg};
                state_next     = S_MMWAIT;
            end
            S_MMWAIT:
            begin
                if (unit_done)
                begin
                    mm_next    = unit_res;
                    ax_next    = '0;
                    state_next = S_Q;
                end
            end
            S_Q:
            begin
                if (dmag_reg[ax_reg] == 33'd0)
                begin
                    if (ax_reg == 2'd2)
                        fld_done = 1'b1;
                    else
                        ax_next = ax_reg + 2'd1;
                end
                else
                begin
                    mul_a      = {1'b0, dmag_reg[ax_reg][31:0]};
                    mul_b      = {1'b0, mm_reg};
                    state_next = S_QST;
                end
            end
            S_QST:
            begin
                unit_ctl.start = 1'b1;
                unit_num       = mul_p[63:0];
                unit_den       = d_reg;
                state_next     = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (unit_done)
                begin
                    if (q_neg)
                        acc_next[ax_reg] = acc_reg[ax_reg] - {32'd0, unit_res};
                    else
                        acc_next[ax_reg] = acc_reg[ax_reg] + {32'd0, unit_res};
                    if (ax_reg == 2'd2)
                        fld_done = 1'b1;
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = S_Q;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fo_x_next      = rffa_pkg::sat32(acc_reg[0]);
                    fo_y_next      = rffa_pkg::sat32(acc_reg[1]);
                    fo_z_next      = rffa_pkg::sat32(acc_reg[2]);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (fld_done)
        begin
            if ((fld_reg + CW'(1)) == n_reg)
                state_next = S_FIN;
            else
            begin
                fld_next   = fld_reg + CW'(1);
                state_next = S_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            fld_reg           <= '0;
            n_reg             <= '0;
            ax_reg            <= '0;
            fields_in_use_reg <= '0;
            field_mode_reg    <= rffa_pkg::MODE_EXPLODE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            fld_reg           <= fld_next;
            n_reg             <= n_next;
            ax_reg            <= ax_next;
            fields_in_use_reg <= fields_in_use_next;
            field_mode_reg    <= field_mode_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        acc_reg    <= acc_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        inside_reg <= inside_next;
        sum_reg    <= sum_next;
        r_reg      <= r_next;
        s_reg      <= s_next;
        d_reg      <= d_next;
        mm_reg     <= mm_next;
        fo_x_reg   <= fo_x_next;
        fo_y_reg   <= fo_y_next;
        fo_z_reg   <= fo_z_next;
    end

    assign out_valid   = out_valid_reg;
    assign force_out_x = fo_x_reg;
    assign force_out_y = fo_y_reg;
    assign force_out_z = fo_z_reg;

    // The shared unit only finishes while the sequencer waits for it.
    `RFFA_ASSERT_IMP(a_unit_done_in_wait, clk, rst_n, unit_done, (state_reg == S_SQRT) || (state_reg == S_MMWAIT) || (state_reg == S_QWAIT))
    `RFFA_ASSERT_IMP(a_read_in_range, clk, rst_n, state_reg == S_READ, fld_reg < n_reg)
    `RFFA_ASSERT_NXT(a_fin_loads_result, clk, rst_n, (state_reg == S_FIN) && !(out_valid_reg && out_stall), out_valid_reg && (state_reg == S_IDLE))

endmodule

### rtl/core/rffa_table.sv
// Field table of the radial force field accumulator: one write port, one
// registered read port. Depends on rffa_pkg.
module rffa_table #(
    parameter int MAX_FIELDS = rffa_pkg::MAX_FIELDS_DEF,
    parameter int AW         = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  rffa_pkg::rffa_entry_t wdata,
    input  logic [AW-1:0]        raddr,
    output rffa_pkg::rffa_entry_t rdata
);

    rffa_pkg::rffa_entry_t mem [MAX_FIELDS];
    rffa_pkg::rffa_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rffa_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on nothing but its ports; used by the top level sequencer.
module rffa_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### rtl/core/rffa_divsqrt.sv
// Shared restoring divide / square root unit, one result bit per cycle.
// Depends on rffa_pkg for its control struct.
module rffa_divsqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rffa_pkg::rffa_unit_ctl_t ctl,
    input  logic [63:0]             num,
    input  logic [31:0]             den,
    output logic                    done,
    output logic [31:0]             result
);

    logic [35:0] rem_reg, rem_next;
    logic [63:0] src_reg, src_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] shifted;
    logic [35:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        src_next  = src_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = sqrt_reg ? {rem_reg[33:0], src_reg[63:62]} : {rem_reg[34:0], src_reg[63]};
        trial     = sqrt_reg ? {2'b00, res_reg, 2'b01} : {4'b0000, den_reg};
        if (ctl.start)
        begin
            // The quotient always fits 32 bits, so the high word is the first remainder.
            sqrt_next = ctl.sqrt_op;
            rem_next  = ctl.sqrt_op ? 36'd0 : {4'b0000, num[63:32]};
            src_next  = ctl.sqrt_op ? num : {num[31:0], 32'd0};
            res_next  = '0;
            den_next  = den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                res_next = {res_reg[30:0], 1'b0};
            end
            src_next = sqrt_reg ? {src_reg[61:0], 2'b00} : {src_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        src_reg  <= src_next;
        res_reg  <= res_next;
        den_reg  <= den_next;
        sqrt_reg <= sqrt_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### verif/tb_radial_force_field_accumulate.sv
// Self-checking testbench for the radial force field accumulator.
// It predicts each particle result from a shadow field table and compares outputs.
// Depends on rffa_pkg and radial_force_field_accumulate.
module tb_radial_force_field_accumulate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 16;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } force_t;

    class force_scoreboard;
        logic signed [31:0] ctr_x[TABLE_DEPTH];
        logic signed [31:0] ctr_y[TABLE_DEPTH];
        logic signed [31:0] ctr_z[TABLE_DEPTH];
        logic [30:0]        reach[TABLE_DEPTH];
        logic signed [31:0] gain[TABLE_DEPTH];
        logic [4:0]         active_fields;
        logic [1:0]         mode;
        force_t             expected_forces[$];
        int                 errors;
        int                 particles;
        int                 loads;

        function new();
            active_fields = 0;
            mode = rffa_pkg::MODE_EXPLODE;
            errors = 0;
            particles = 0;
            loads = 0;
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            errors++;
        endfunction

        function void set_reg(logic idx, logic [4:0] value);
            if (idx == rffa_pkg::CFG_FIELDS)
                active_fields = value;
            else
                mode = value[1:0];
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res;
            longint unsigned cand;
            res = 0;
            for (int b = 31; b >= 0; b--) begin
                cand = res | (64'd1 << b);
                if (cand * cand <= v)
                    res = cand;
            end
            return res;
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function void note_item(logic f, logic [3:0] idx, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] pz,
                                logic [30:0] rch, logic signed [31:0] g,
                                logic signed [31:0] fx, logic signed [31:0] fy,
                                logic signed [31:0] fz);
            longint acc[3];
            longint pos[3];
            longint delta[3];
            longint s;
            longint unsigned mag[3];
            longint unsigned r;
            longint unsigned sum;
            longint unsigned d;
            longint unsigned scaled;
            longint unsigned q;
            bit in_field;
            bit neg;
            int n;
            force_t res;
            if (f == rffa_pkg::FUNC_LOAD) begin
                ctr_x[idx] = px;
                ctr_y[idx] = py;
                ctr_z[idx] = pz;
                reach[idx] = rch;
                gain[idx] = g;
                loads++;
                return;
            end
            particles++;
            pos[0] = px;
            pos[1] = py;
            pos[2] = pz;
            acc[0] = fx;
            acc[1] = fy;
            acc[2] = fz;
            n = (active_fields > TABLE_DEPTH) ? TABLE_DEPTH : active_fields;
            for (int j = 0; j < n; j++) begin
                r = reach[j];
                s = gain[j];
                delta[0] = pos[0] - longint'(ctr_x[j]);
                delta[1] = pos[1] - longint'(ctr_y[j]);
                delta[2] = pos[2] - longint'(ctr_z[j]);
                sum = 0;
                in_field = 1;
                for (int a = 0; a < 3; a++) begin
                    mag[a] = (delta[a] < 0) ? -delta[a] : delta[a];
                    if (mag[a] >= r)
                        in_field = 0;
                    else
                        sum += mag[a] * mag[a];
                end
                // A particle sitting exactly on a center gets nothing from that field.
                if (!in_field || sum >= r * r || sum == 0)
                    continue;
                if (mode == rffa_pkg::MODE_EXPLODE) begin
                    for (int a = 0; a < 3; a++)
                        acc[a] += (delta[a] * s) >>> 16;
                end else if (mode == rffa_pkg::MODE_IMPLODE) begin
                    for (int a = 0; a < 3; a++)
                        acc[a] += (-delta[a] * s) >>> 16;
                end else if (mode == rffa_pkg::MODE_FALLOFF) begin
                    d = int_root(sum);
                    scaled = longint'((s < 0) ? -s : s) * (r - d) / r;
                    for (int a = 0; a < 3; a++) begin
                        q = (delta[a] == 0) ? 0 : mag[a] * scaled / d;
                        neg = (delta[a] > 0) != (s < 0);
                        acc[a] += neg ? -longint'(q) : longint'(q);
                    end
                end
            end
            res.x = clip32(acc[0]);
            res.y = clip32(acc[1]);
            res.z = clip32(acc[2]);
            expected_forces.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] ox, logic signed [31:0] oy,
                                   logic signed [31:0] oz);
            force_t e;
            if (expected_forces.size() == 0) begin
                report($sformatf("unexpected result %h %h %h", ox, oy, oz));
                return;
            end
            e = expected_forces.pop_front();
            if (ox !== e.x)
                report($sformatf("force x got %h want %h", ox, e.x));
            if (oy !== e.y)
                report($sformatf("force y got %h want %h", oy, e.y));
            if (oz !== e.z)
                report($sformatf("force z got %h want %h", oz, e.z));
        endfunction

        function int pending();
            return expected_forces.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [3:0]         index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [30:0]        field_reach;
    logic signed [31:0] field_gain;
    logic signed [31:0] force_in_x;
    logic signed [31:0] force_in_y;
    logic signed [31:0] force_in_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] force_out_x;
    logic signed [31:0] force_out_y;
    logic signed [31:0] force_out_z;
    logic               cfg_we;
    logic               cfg_index;
    logic [4:0]         cfg_data;

    force_scoreboard sb = new();
    int stall_hold;
    int settings_used;
    bit no_gaps;

    radial_force_field_accumulate dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .index(index), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .field_reach(field_reach), .field_gain(field_gain),
        .force_in_x(force_in_x), .force_in_y(force_in_y), .force_in_z(force_in_z),
        .out_valid(out_valid), .out_stall(out_stall), .force_out_x(force_out_x),
        .force_out_y(force_out_y), .force_out_z(force_out_z), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("tb_radial_force_field_accumulate NOT OK");
        $finish;
    end

    // Both channels are observed here, with values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_item(func, index, coord_x, coord_y, coord_z, field_reach,
                             field_gain, force_in_x, force_in_y, force_in_z);
            if (out_valid && !out_stall)
                sb.check_result(force_out_x, force_out_y, force_out_z);
        end
    end

    // Result side back-pressure: mostly short bursts, now and then a long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 3);
        end
    end

    task automatic send_item(logic f, logic [3:0] idx, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz,
                             logic [30:0] rch, logic signed [31:0] g,
                             logic signed [31:0] fx, logic signed [31:0] fy,
                             logic signed [31:0] fz);
        int gap;
        func <= f;
        index <= idx;
        coord_x <= px;
        coord_y <= py;
        coord_z <= pz;
        field_reach <= rch;
        field_gain <= g;
        force_in_x <= fx;
        force_in_y <= fy;
        force_in_z <= fz;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = 0;
        if (!no_gaps) begin
            if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(10, 60);
            else if ($urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic idx, logic [4:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drains outstanding results, then gives the block time to go idle.
    // The first edge lets the monitor note an item accepted at the last edge.
    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (sb.pending() > 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_force();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $signed($urandom) >>> $urandom_range(4, 12);
    endfunction

    task automatic load_shaped(logic [3:0] idx);
        logic [31:0] rb;
        logic [30:0] rch;
        rb = $urandom;
        case ($urandom_range(0, 3))
            0: rch = $urandom_range(32'h1_0000, 32'h4_0000);
            1: rch = $urandom_range(0, 32'h40_0000);
            2: rch = $urandom >> 1;
            default: rch = $urandom_range(0, 100);
        endcase
        send_item(rffa_pkg::FUNC_LOAD, idx, $signed({{12{rb[19]}}, rb[19:0]}),
                  $signed({{12{rb[27]}}, rb[27:8]}), $signed($urandom) >>> 12, rch,
                  $signed($urandom) >>> $urandom_range(0, 20), $urandom, $urandom,
                  $urandom);
    endtask

    // Places a particle inside, near or on the center of a field in use.
    task automatic particle_shaped();
        int j;
        int n;
        longint unsigned lim;
        longint off[3];
        bit on_center;
        n = (sb.active_fields > TABLE_DEPTH) ? TABLE_DEPTH : sb.active_fields;
        j = (n == 0) ? $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, n - 1);
        lim = longint'(sb.reach[j]) * 3 / 5 + 1;
        on_center = ($urandom_range(0, 9) == 0);
        for (int a = 0; a < 3; a++) begin
            off[a] = longint'($urandom) % lim;
            if ($urandom_range(0, 1))
                off[a] = -off[a];
            if (on_center || $urandom_range(0, 3) == 0)
                off[a] = 0;
        end
        send_item(rffa_pkg::FUNC_PARTICLE, $urandom, sb.ctr_x[j] + off[0],
                  sb.ctr_y[j] + off[1], sb.ctr_z[j] + off[2], $urandom, $urandom,
                  rand_force(), rand_force(), rand_force());
    endtask

    initial
    begin
        logic [4:0] phase_fields[9];
        logic [1:0] phase_mode[9];
        int pick;
        phase_fields = '{5'd3, 5'd16, 5'd31, 5'd0, 5'd2, 5'd5, 5'd1, 5'd4, 5'd16};
        phase_mode = '{rffa_pkg::MODE_IMPLODE, rffa_pkg::MODE_FALLOFF, MODE_UNUSED,
                       rffa_pkg::MODE_EXPLODE, rffa_pkg::MODE_FALLOFF,
                       rffa_pkg::MODE_EXPLODE, rffa_pkg::MODE_IMPLODE,
                       rffa_pkg::MODE_FALLOFF, rffa_pkg::MODE_EXPLODE};
        no_gaps = 0;
        settings_used = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= rffa_pkg::FUNC_LOAD;
        index <= '0;
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
        field_reach <= '0;
        field_gain <= '0;
        force_in_x <= '0;
        force_in_y <= '0;
        force_in_z <= '0;
        cfg_we <= 1'b0;
        cfg_index <= rffa_pkg::CFG_FIELDS;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no fields in use the force only passes through the saturation.
        write_reg(rffa_pkg::CFG_FIELDS, 5'd0);
        write_reg(rffa_pkg::CFG_MODE, rffa_pkg::MODE_EXPLODE);
        send_item(rffa_pkg::FUNC_PARTICLE, 4'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                  '0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1);

        send_item(rffa_pkg::FUNC_LOAD, 4'd0, 0, 0, 0, 31'h7FFF_FFFF, 32'sh8000_0000,
                  0, 0, 0);
        send_item(rffa_pkg::FUNC_LOAD, 4'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 31'h10_0000, 32'sh7FFF_FFFF, 0, 0, 0);
        send_item(rffa_pkg::FUNC_LOAD, 4'd2, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 31'h10_0000, 32'sh1, 0, 0, 0);
        send_item(rffa_pkg::FUNC_LOAD, 4'd3, 0, 0, 0, 31'h0, -32'sh1, 0, 0, 0);
        for (int i = 4; i < TABLE_DEPTH; i++)
            load_shaped(i);
        drain();
        write_reg(rffa_pkg::CFG_FIELDS, 5'd16);
        settings_used++;
        // Far out in the widest field the sums saturate.
        send_item(rffa_pkg::FUNC_PARTICLE, 4'd15, 32'sh4000_0000, 0, -32'sh4000_0000,
                  '1, '1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(rffa_pkg::FUNC_PARTICLE, 4'd0, 0, 0, 0, '0, '0, 32'sh8000_0000, 0,
                  32'sh7FFF_FFFF);
        send_item(rffa_pkg::FUNC_PARTICLE, 4'd0, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFF0, '0, '0, 1, 2, 3);
        send_item(rffa_pkg::FUNC_PARTICLE, 4'd0, 32'sh8000_0005, 32'sh8000_0000,
                  32'sh8000_0100, '0, '0, -1, -2, -3);
        send_item(rffa_pkg::FUNC_PARTICLE, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            write_reg(rffa_pkg::CFG_FIELDS, phase_fields[ph]);
            write_reg(rffa_pkg::CFG_MODE, phase_mode[ph]);
            settings_used++;
            for (int i = 0; i < 128; i++) begin
                no_gaps = (i >= 40 && i < 60);
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    load_shaped($urandom_range(0, TABLE_DEPTH - 1));
                else if (pick < 18)
                    send_item(rffa_pkg::FUNC_PARTICLE, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                else if (pick < 22)
                    send_item(rffa_pkg::FUNC_LOAD, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                else
                    particle_shaped();
            end
        end
        drain();
        repeat (40) @(posedge clk);

        $display("covered %0d particle items and %0d table loads", sb.particles, sb.loads);
        $display("over %0d register settings, all three modes and the unused one",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_radial_force_field_accumulate OK");
        else
            $display("tb_radial_force_field_accumulate NOT OK");
        $finish;
    end
endmodule
